FILE: rtl/core/dcbc_pkg.sv
// Package with DES tables, permutation functions and shared types for the DES-CBC block.
package dcbc_pkg;

   localparam int unsigned BLOCK_BITS = 64;
   localparam int unsigned HALF_KEY_BITS = 28;
   localparam int unsigned SUBKEY_BITS = 48;
   localparam int unsigned KEY_PERM_BITS = 56;
   localparam int unsigned NUM_ROUNDS = 16;
   localparam int unsigned ROUND_BITS = 4;

   localparam logic [1:0] CSR_KEY = 2'd0;
   localparam logic [1:0] CSR_IV = 2'd1;
   localparam logic [1:0] CSR_MODE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic round;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic last_round;
   } dp_status_type;

   localparam logic [7:0] TAB_IP [64] = '{
      58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
      57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
   localparam logic [7:0] TAB_FP [64] = '{
      40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
      36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
   localparam logic [7:0] TAB_E [48] = '{
      32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
      16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
   localparam logic [7:0] TAB_P [32] = '{
      16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
   localparam logic [7:0] TAB_PC1 [56] = '{
      57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,60,52,44,36,
      63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,29,21,13,5,28,20,12,4};
   localparam logic [7:0] TAB_PC2 [48] = '{
      14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
      41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
   localparam logic [15:0] TAB_ROT_TWO = 16'b0011_1111_0111_1110;
   localparam logic [3:0] TAB_SBOX [8][64] = '{
      '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
        4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
      '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
        0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
      '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
        13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
      '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
        10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
      '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
        4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
      '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
        9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
      '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
        1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
      '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
        7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,2,1,14,7,4,10,8,13,15,12,9,0,5,6,3,11}};

   function automatic logic [63:0] perm_ip(input logic [63:0] v);
      logic [63:0] r;
      for (int i = 0; i < 64; i++) r[63-i] = v[64-TAB_IP[i]];
      return r;
   endfunction

   function automatic logic [63:0] perm_fp(input logic [63:0] v);
      logic [63:0] r;
      for (int i = 0; i < 64; i++) r[63-i] = v[64-TAB_FP[i]];
      return r;
   endfunction

   function automatic logic [55:0] perm_pc1(input logic [63:0] v);
      logic [55:0] r;
      for (int i = 0; i < 56; i++) r[55-i] = v[64-TAB_PC1[i]];
      return r;
   endfunction

   function automatic logic [47:0] perm_pc2(input logic [55:0] v);
      logic [47:0] r;
      for (int i = 0; i < 48; i++) r[47-i] = v[56-TAB_PC2[i]];
      return r;
   endfunction

   function automatic logic [31:0] round_f(input logic [31:0] r, input logic [47:0] k);
      logic [47:0] x;
      logic [5:0] six;
      logic [31:0] s;
      logic [31:0] p;
      for (int i = 0; i < 48; i++) x[47-i] = r[32-TAB_E[i]];
      x = x ^ k;
      for (int i = 0; i < 8; i++) begin
         six = x[47-6*i -: 6];
         s[31-4*i -: 4] = TAB_SBOX[i][{six[5], six[0], six[4:1]}];
      end
      for (int i = 0; i < 32; i++) p[31-i] = s[32-TAB_P[i]];
      return p;
   endfunction

endpackage

FILE: rtl/core/dcbc_ctrl.sv
// Controller state machine that sequences the sixteen DES rounds and the result handshake.
module dcbc_ctrl
   import dcbc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (status.last_round) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            cmd.finish = status.last_round;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
         end
         default: ;
      endcase
   end

   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.round)) else $error("load and round commands overlap");
   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid) else $error("result not shown after last round");
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input taken while result pending");

endmodule

FILE: rtl/core/dcbc_dp.sv
// Datapath with the shared DES round unit, key schedule registers and CBC chaining register.
module dcbc_dp
   import dcbc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic [63:0]   req_data_block,
   input  logic          req_chain_start,
   input  logic [63:0]   key,
   input  logic [63:0]   iv,
   input  logic          dec,
   output logic [63:0]   rsp_result_block
);

   logic [ROUND_BITS-1:0] round_ff, round_in;
   logic [27:0] c_ff, c_in, d_ff, d_in;
   logic [31:0] l_ff, l_in, r_ff, r_in;
   logic [63:0] chain_ff, chain_in;
   logic [63:0] data_ff, data_in;
   logic [63:0] result_ff, result_in;
   logic        dec_ff, dec_in;

   logic [55:0] cd0;
   logic [63:0] ip_val, fin_val, chain_sel, des_out;
   logic [27:0] c_nx, d_nx, c_rot, d_rot;
   logic [47:0] subkey;
   logic        two;

   assign cd0 = perm_pc1(key);
   assign chain_sel = req_chain_start ? iv : chain_ff;
   assign ip_val = perm_ip(dec ? req_data_block : (req_data_block ^ chain_sel));
   assign two = TAB_ROT_TWO[4'(NUM_ROUNDS-1) - round_ff];

   always_comb begin
      // Encrypt rotates left before use; decrypt uses the current pair, then rotates right.
      if (two) begin
         c_rot = {c_ff[25:0], c_ff[27:26]};
         d_rot = {d_ff[25:0], d_ff[27:26]};
      end else begin
         c_rot = {c_ff[26:0], c_ff[27]};
         d_rot = {d_ff[26:0], d_ff[27]};
      end
      if (dec_ff) begin
         subkey = perm_pc2({c_ff, d_ff});
         if (TAB_ROT_TWO[4'(NUM_ROUNDS-1) - (round_ff + 4'd1)]) begin
            c_nx = {c_ff[1:0], c_ff[27:2]};
            d_nx = {d_ff[1:0], d_ff[27:2]};
         end else begin
            c_nx = {c_ff[0], c_ff[27:1]};
            d_nx = {d_ff[0], d_ff[27:1]};
         end
      end else begin
         subkey = perm_pc2({c_rot, d_rot});
         c_nx = c_rot;
         d_nx = d_rot;
      end
   end

   assign fin_val = perm_fp({l_ff ^ round_f(r_ff, subkey), r_ff});
   assign des_out = dec_ff ? (fin_val ^ data_ff) : fin_val;

   always_comb begin
      round_in = round_ff;
      c_in = c_ff;
      d_in = d_ff;
      l_in = l_ff;
      r_in = r_ff;
      chain_in = chain_ff;
      data_in = data_ff;
      result_in = result_ff;
      dec_in = dec_ff;
      if (cmd.load) begin
         round_in = '0;
         dec_in = dec;
         // Decrypt starts from K16, whose C and D equal the PC-1 output.
         c_in = cd0[55:28];
         d_in = cd0[27:0];
         l_in = ip_val[63:32];
         r_in = ip_val[31:0];
         data_in = dec ? chain_sel : 64'd0;
         chain_in = dec ? req_data_block : chain_ff;
      end else if (cmd.round) begin
         round_in = round_ff + 4'd1;
         c_in = c_nx;
         d_in = d_nx;
         l_in = r_ff;
         r_in = l_ff ^ round_f(r_ff, subkey);
         if (cmd.finish) begin
            result_in = des_out;
            if (!dec_ff) chain_in = des_out;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         round_ff <= '0;
         chain_ff <= '0;
      end else begin
         round_ff <= round_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      c_ff <= c_in;
      d_ff <= d_in;
      l_ff <= l_in;
      r_ff <= r_in;
      data_ff <= data_in;
      result_ff <= result_in;
      dec_ff <= dec_in;
   end

   assign status.last_round = (round_ff == 4'(NUM_ROUNDS-1));
   assign rsp_result_block = result_ff;

   a_round_start: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> round_ff == '0) else $error("round counter not cleared on load");
   a_finish_last: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> status.last_round) else $error("finish before last round");
   a_chain_dec: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && dec) |=> chain_ff == $past(req_data_block))
      else $error("decrypt chain not updated");

endmodule

FILE: rtl/core/des_cbc_block_cipher_top.sv
// Top level of the DES-CBC block cipher with configuration registers.
// A 64-bit block is loaded at its acceptance edge and then runs sixteen rounds through a single
// shared round unit, and its result is held in an output register until taken. The block returns
// to idle in the cycle after the result transaction. A new block is accepted only after the
// previous result transaction, since the CBC chain value of each block depends on the one before.
module des_cbc_block_cipher_top
   import dcbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_data_block,
   input  logic        req_chain_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_result_block,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   logic [63:0] key_ff, iv_ff;
   logic        mode_ff;
   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
         iv_ff <= '0;
         mode_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_KEY: key_ff <= csr_data;
            CSR_IV: iv_ff <= csr_data;
            CSR_MODE: mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   dcbc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .status(status), .cmd(cmd)
   );

   dcbc_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_data_block(req_data_block), .req_chain_start(req_chain_start),
      .key(key_ff), .iv(iv_ff), .dec(mode_ff), .rsp_result_block(rsp_result_block)
   );

endmodule
